>>> design/efe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the escaped frame encoder.
// No dependencies; every other design file depends on this package.
package efe_pkg;

    localparam int BYTE_W = 8;

    // Line codes of the framing scheme.
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1a;
    localparam logic [BYTE_W-1:0] END_BYTE = 8'h1b;
    localparam logic [BYTE_W-1:0] XOR_MASK = 8'h20;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One classified payload byte, as handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_esc;
        logic              last;
        logic [BYTE_W-1:0] sum_byte;
        logic              sum_esc;
    } cmd_t;

    // A byte must be escaped when it collides with one of the line codes.
    function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
        return (b == ESC_BYTE) || (b == END_BYTE);
    endfunction

endpackage

`default_nettype wire

>>> design/efe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the payload input and the line output.
// Depends on efe_pkg for the byte width.

interface efe_in_if;
    logic                      valid;
    logic                      ready;
    logic [efe_pkg::BYTE_W-1:0] payload_byte;
    logic                      packet_last;

    modport source (output valid, output payload_byte, output packet_last, input ready);
    modport sink   (input valid, input payload_byte, input packet_last, output ready);
endinterface

interface efe_out_if;
    logic                      valid;
    logic                      ready;
    logic [efe_pkg::BYTE_W-1:0] line_byte;
    logic                      run_last;
    logic                      frame_done;

    modport source (output valid, output line_byte, output run_last, output frame_done,
                    input ready);
    modport sink   (input valid, input line_byte, input run_last, input frame_done,
                    output ready);
endinterface

`default_nettype wire

>>> design/efe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts payload transactions, keeps the running sum and
// classifies each byte into a command. Depends on efe_pkg and efe_if.
module efe_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    efe_in_if.sink            payload,
    output logic              push_valid,
    input  wire logic         push_ready,
    output efe_pkg::cmd_t     push_cmd
);
    import efe_pkg::*;

    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] sum_incl;
    logic              accept;

    // A transaction is taken whenever the queue has room.
    assign payload.ready = push_ready;
    assign push_valid    = payload.valid;
    assign accept        = payload.valid && push_ready;

    // The checksum includes the current byte; it wraps modulo 256.
    assign sum_incl = sum_reg + payload.payload_byte;

    // Classify the byte and its checksum for the back end.
    always_comb
    begin
        push_cmd.data_byte = payload.payload_byte;
        push_cmd.data_esc  = needs_escape(payload.payload_byte);
        push_cmd.last      = payload.packet_last;
        push_cmd.sum_byte  = sum_incl;
        push_cmd.sum_esc   = needs_escape(sum_incl);
    end

    // The sum restarts after the last byte of a packet.
    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = payload.packet_last ? '0 : sum_incl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> design/efe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short FIFO of classified commands between the front and the back end.
// Depends on efe_pkg for the command type.
module efe_queue #(
    parameter int DEPTH = efe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire efe_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output efe_pkg::cmd_t      pop_cmd
);
    import efe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = entries[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/efe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: steps through the line bytes of each queued command and drives
// the registered output channel. Depends on efe_pkg and efe_if.
module efe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire efe_pkg::cmd_t pop_cmd,
    efe_out_if.source          line
);
    import efe_pkg::*;

    typedef enum logic [4:0] {
        S_DATA     = 5'b00001,
        S_DATA_ESC = 5'b00010,
        S_SUM      = 5'b00100,
        S_SUM_ESC  = 5'b01000,
        S_END      = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] line_byte_reg;
    logic              run_last_reg;
    logic              frame_done_reg;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              emit_done;
    logic              emit_pop;
    logic              load;

    // A byte is produced whenever a command waits and the output slot frees up.
    assign load      = pop_valid && (!out_valid_reg || line.ready);
    assign pop_ready = load && emit_pop;

    // Choose the byte for the current step and the step that follows.
    always_comb
    begin
        emit_byte  = pop_cmd.data_byte;
        emit_last  = 1'b0;
        emit_done  = 1'b0;
        emit_pop   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_DATA:
            begin
                if (pop_cmd.data_esc)
                begin
                    emit_byte  = ESC_BYTE;
                    state_next = S_DATA_ESC;
                end
                else if (pop_cmd.last)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    emit_last = 1'b1;
                    emit_pop  = 1'b1;
                end
            end
            S_DATA_ESC:
            begin
                emit_byte = pop_cmd.data_byte ^ XOR_MASK;
                if (pop_cmd.last)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    emit_last  = 1'b1;
                    emit_pop   = 1'b1;
                    state_next = S_DATA;
                end
            end
            S_SUM:
            begin
                if (pop_cmd.sum_esc)
                begin
                    emit_byte  = ESC_BYTE;
                    state_next = S_SUM_ESC;
                end
                else
                begin
                    emit_byte  = pop_cmd.sum_byte;
                    state_next = S_END;
                end
            end
            S_SUM_ESC:
            begin
                emit_byte  = pop_cmd.sum_byte ^ XOR_MASK;
                state_next = S_END;
            end
            S_END:
            begin
                emit_byte  = END_BYTE;
                emit_last  = 1'b1;
                emit_done  = 1'b1;
                emit_pop   = 1'b1;
                state_next = S_DATA;
            end
            default:
            begin
                state_next = S_DATA;
            end
        endcase
    end

    // The output slot empties when taken and refills on every load.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (line.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_byte_reg  <= emit_byte;
            run_last_reg   <= emit_last;
            frame_done_reg <= emit_done;
        end
    end

    assign line.valid      = out_valid_reg;
    assign line.line_byte  = line_byte_reg;
    assign line.run_last   = run_last_reg;
    assign line.frame_done = frame_done_reg;

endmodule

`default_nettype wire

>>> design/escaped_frame_encoder_unit.sv
// Escaped frame encoder: byte-stuffing framer with an 8-bit additive checksum.
//
// The payload channel takes one raw byte per transaction with packet_last
// set on the final byte of a packet. The line channel gives one framed byte
// per transaction. A byte equal to 0x1a or 0x1b goes out as 0x1a followed by
// the byte XOR 0x20. After the last byte come the escaped checksum (modulo-256
// sum of the packet's bytes) and the terminator 0x1b, flagged by frame_done.
// run_last marks the final line byte caused by each payload transaction.
//
// The first line byte of a payload transaction passes the command queue and
// then the output register before it is valid. Throughput: while the line
// receiver takes its bytes, the back end emits one line byte per cycle. An
// item causes 1 or 2 line bytes for an inner byte and 3 to 5 for a last byte.
// The front end takes one item per cycle while the command queue has room.
//
// Reset clears the running sum, the queue and the output valid. When the line
// receiver stalls, the output register holds its byte, the queue fills, and
// the payload channel then drops ready until space frees up.
`timescale 1ns / 1ps
`default_nettype none
// Top level; instantiates efe_front, efe_queue and efe_back.
// Depends on efe_pkg and efe_if.
module escaped_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    efe_in_if.sink    payload,
    efe_out_if.source line
);
    import efe_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // Classification and checksum.
    efe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decoupling queue.
    efe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Line byte sequencing.
    efe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .line      (line)
    );

endmodule

`default_nettype wire
